// File: rtl/core/thermostat_deadband_controller_macros.svh
// ----------------------------------------------------------------------------
// thermostat deadband controller assertion macros
// shared property shorthands for the checker of the controller
// ----------------------------------------------------------------------------
`ifndef THERMOSTAT_DEADBAND_CONTROLLER_MACROS_SVH
`define THERMOSTAT_DEADBAND_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define TDC_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tdc check failed");

// next-cycle implication, disabled while reset is held
`define TDC_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tdc check failed");

`endif

// File: rtl/core/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// constants, register codes and beat layout of the thermostat controller
// ----------------------------------------------------------------------------
package tdc_pkg;

    // moving average depth and derived widths
    localparam int AVG_DEPTH  = 10;
    localparam int POS_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W      = $clog2(255 * AVG_DEPTH + 1);

    // divide by depth as multiply by a rounded-up reciprocal
    localparam int DIV_SHIFT  = SUM_W + POS_W + 1;
    localparam int DIV_RECIP  = ((2 ** DIV_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam int PROD_W     = SUM_W + DIV_SHIFT;

    // field widths
    localparam int TEMP_W     = 8;
    localparam int BAND_W     = 5;
    localparam int STEP_W     = 4;
    localparam int CFG_DATA_W = 8;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // reset values
    localparam logic [BAND_W-1:0] BAND_RST     = 5'd5;
    localparam logic [STEP_W-1:0] STEP_RST     = 4'd5;
    localparam logic [TEMP_W-1:0] SET_MIN_RST  = 8'd35;
    localparam logic [TEMP_W-1:0] SET_MAX_RST  = 8'd75;
    localparam logic [TEMP_W-1:0] SET_PT_RST   = 8'd60;

    // result beat bit positions
    localparam int OUT_HEAT_BIT = 0;
    localparam int OUT_COOL_BIT = 1;
    localparam int OUT_LAMP_BIT = 2;
    localparam int OUT_DISP_BIT = 3;
    localparam int OUT_AVG_LSB  = 4;
    localparam int OUT_PWR_BIT  = 12;
    localparam int OUT_SET_LSB  = 13;

    // configuration register index codes
    typedef enum logic [1:0] {
        CFG_BAND_WIDTH  = 2'd0,
        CFG_SET_STEP    = 2'd1,
        CFG_SET_MINIMUM = 2'd2,
        CFG_SET_MAXIMUM = 2'd3
    } cfg_index_t;

endpackage

// File: rtl/core/thermostat_deadband_controller.sv
// ----------------------------------------------------------------------------
// thermostat_deadband_controller
// bang-bang thermostat with button set point and moving average display
// ----------------------------------------------------------------------------
// One sensor beat in, one result beat out. A new beat is taken every clock
// cycle while results drain; its result beat is presented from the output
// register: the input register takes the beat, then the set point, ring sum
// update, divide by the ring depth and deadband compare run as one stage
// into the output register. While a result waits, the input register still
// takes one more beat; with both registers full the input stalls until the
// result drains. The ten-entry sample ring lives in flip-flops and is primed
// from the first sample taken while powered, so no clearing pass follows reset.
module thermostat_deadband_controller
    import tdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sensor beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // temp_sample[7:0], power_button_level[8], up_button_level[9],
    // down_button_level[10], zero fill[15:11]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // heater_drive[0], cooler_drive[1], lamp_drive[2], display_enable[3],
    // display_value[11:4], powered[12], target_temp[20:13], zero fill[23:21]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // configuration registers
    logic [BAND_W-1:0]     band_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [TEMP_W-1:0]     set_min_reg;
    logic [TEMP_W-1:0]     set_max_reg;

    // input stage
    logic                  in_valid_reg;
    logic [TEMP_W-1:0]     in_temp_reg;
    logic [2:0]            in_levels_reg;

    // controller state
    logic                  power_on_reg;
    logic                  power_on_next;
    logic [2:0]            prev_levels_reg;
    logic [TEMP_W-1:0]     set_point_reg;
    logic [TEMP_W-1:0]     set_point_next;
    logic [TEMP_W-1:0]     ring_reg [AVG_DEPTH];
    logic [POS_W-1:0]      ring_pos_reg;
    logic [POS_W-1:0]      ring_pos_next;
    logic [SUM_W-1:0]      ring_sum_reg;
    logic [SUM_W-1:0]      ring_sum_next;
    logic                  primed_reg;

    // output stage
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    // datapath
    logic                  advance;
    logic                  prime_now;
    logic [2:0]            falls;
    logic [TEMP_W:0]       up_sum;
    logic [TEMP_W-1:0]     set_after_up;
    logic [PROD_W-1:0]     avg_prod;
    logic [TEMP_W-1:0]     avg;
    logic [TEMP_W-1:0]     avg_out;
    logic                  heat;
    logic                  cool;
    logic                  lamp;

    // handshake: the stage moves when the output register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // button edges and set point stepping
    always_comb begin
        falls         = prev_levels_reg & ~in_levels_reg;
        power_on_next = power_on_reg ^ falls[0];

        up_sum        = {1'b0, set_point_reg} + {{(TEMP_W + 1 - STEP_W){1'b0}}, step_reg};
        set_after_up  = set_point_reg;
        if (falls[1] && (set_point_reg < set_max_reg)) begin
            set_after_up = up_sum[TEMP_W] ? {TEMP_W{1'b1}} : up_sum[TEMP_W-1:0];
        end

        set_point_next = set_after_up;
        if (falls[2] && (set_after_up > set_min_reg)) begin
            if (set_after_up > {{(TEMP_W - STEP_W){1'b0}}, step_reg}) begin
                set_point_next = set_after_up - {{(TEMP_W - STEP_W){1'b0}}, step_reg};
            end else begin
                set_point_next = '0;
            end
        end
    end

    // ring sum update, priming fills the whole ring with the sample
    always_comb begin
        prime_now     = power_on_next && !primed_reg;
        ring_sum_next = ring_sum_reg;
        ring_pos_next = ring_pos_reg;
        if (prime_now) begin
            ring_sum_next = SUM_W'(in_temp_reg) * SUM_W'(AVG_DEPTH);
            ring_pos_next = (AVG_DEPTH > 1) ? POS_W'(1) : '0;
        end else if (power_on_next) begin
            ring_sum_next = ring_sum_reg - SUM_W'(ring_reg[ring_pos_reg])
                          + SUM_W'(in_temp_reg);
            ring_pos_next = (ring_pos_reg == POS_W'(AVG_DEPTH - 1)) ? '0
                          : ring_pos_reg + POS_W'(1);
        end
    end

    // average and deadband decision
    always_comb begin
        avg_prod = PROD_W'(ring_sum_next) * PROD_W'(DIV_RECIP);
        avg      = avg_prod[DIV_SHIFT +: TEMP_W];
        heat     = power_on_next && (({1'b0, avg} + {{(TEMP_W + 1 - BAND_W){1'b0}}, band_reg})
                   < {1'b0, set_point_next});
        cool     = power_on_next && ({1'b0, avg}
                   > ({1'b0, set_point_next} + {{(TEMP_W + 1 - BAND_W){1'b0}}, band_reg}));
        lamp     = heat || cool;
        avg_out  = power_on_next ? avg : '0;
        out_data_next = {3'b000, set_point_next, power_on_next, avg_out,
                         power_on_next, lamp, cool, heat};
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg    <= BAND_RST;
            step_reg    <= STEP_RST;
            set_min_reg <= SET_MIN_RST;
            set_max_reg <= SET_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BAND_WIDTH:  band_reg    <= cfg_data[BAND_W-1:0];
                CFG_SET_STEP:    step_reg    <= cfg_data[STEP_W-1:0];
                CFG_SET_MINIMUM: set_min_reg <= cfg_data[TEMP_W-1:0];
                CFG_SET_MAXIMUM: set_max_reg <= cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_temp_reg   <= s_tdata[7:0];
            in_levels_reg <= s_tdata[10:8];
        end
    end

    // controller state, updated as each beat moves to the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_on_reg    <= 1'b0;
            prev_levels_reg <= 3'b111;
            set_point_reg   <= SET_PT_RST;
            ring_pos_reg    <= '0;
            ring_sum_reg    <= '0;
            primed_reg      <= 1'b0;
        end else if (advance) begin
            power_on_reg    <= power_on_next;
            prev_levels_reg <= in_levels_reg;
            set_point_reg   <= set_point_next;
            ring_pos_reg    <= ring_pos_next;
            ring_sum_reg    <= ring_sum_next;
            primed_reg      <= primed_reg || power_on_next;
        end
    end

    // sample ring, no reset: never read before it is primed
    always_ff @(posedge aclk) begin
        if (advance && prime_now) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                ring_reg[i] <= in_temp_reg;
            end
        end else if (advance && power_on_next) begin
            ring_reg[ring_pos_reg] <= in_temp_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// File: rtl/core/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_checker
// port-level checks of the thermostat controller result beats
// ----------------------------------------------------------------------------
`include "thermostat_deadband_controller_macros.svh"

module tdc_checker
    import tdc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // unpacked result fields
    logic heat_bit;
    logic cool_bit;
    logic lamp_bit;
    logic disp_bit;
    logic pwr_bit;
    logic drive_ok;
    logic out_dark;

    assign heat_bit = m_tdata[OUT_HEAT_BIT];
    assign cool_bit = m_tdata[OUT_COOL_BIT];
    assign lamp_bit = m_tdata[OUT_LAMP_BIT];
    assign disp_bit = m_tdata[OUT_DISP_BIT];
    assign pwr_bit  = m_tdata[OUT_PWR_BIT];

    // drive and display summaries
    assign drive_ok = !(heat_bit && cool_bit) && (lamp_bit == (heat_bit || cool_bit));
    assign out_dark = (m_tdata[OUT_AVG_LSB +: TEMP_W] == '0) && !lamp_bit && !disp_bit;

    // heater and cooler never fight, lamp follows either drive
    `TDC_ASSERT_IMP(a_drive_excl, aclk, aresetn, m_tvalid, drive_ok)

    // while off all drives and the display are dark
    `TDC_ASSERT_IMP(a_off_dark, aclk, aresetn, m_tvalid && !pwr_bit, out_dark)

    // display enable tracks the power state
    `TDC_ASSERT_IMP(a_disp_pwr, aclk, aresetn, m_tvalid, disp_bit == pwr_bit)

    // a stalled result beat holds
    `TDC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind thermostat_deadband_controller tdc_checker u_tdc_checker (.*);
